// ===== rtl/core/rmq_pkg.sv =====
`timescale 1ns / 1ps

package rmq_pkg;

  // Default number format: signed Q1.16 in 18 bits.
  localparam int unsigned DataWidthDef = 18;
  localparam int unsigned FracBitsDef  = 16;

  // Which quaternion component is the largest one.
  typedef enum logic [1:0] {
    MAIN_X = 2'd0,
    MAIN_Y = 2'd1,
    MAIN_Z = 2'd2,
    MAIN_W = 2'd3
  } main_idx_e;

  // Control bits that travel beside the divider lanes.
  typedef struct packed {
    logic      degen;
    main_idx_e idx;
    logic      neg_a;
    logic      neg_b;
    logic      neg_c;
  } ctrl_t;

  localparam int unsigned CtrlW = $bits(ctrl_t);

endpackage

// ===== rtl/core/rmq_if.sv =====
`timescale 1ns / 1ps

// Matrix input channel.
interface rmq_in_if #(
  parameter int unsigned W = 18
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m00, m01, m02;
  logic signed [W-1:0] m10, m11, m12;
  logic signed [W-1:0] m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

// Quaternion result channel.
interface rmq_out_if #(
  parameter int unsigned W = 18
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] q_x, q_y, q_z, q_w;
  logic                degenerate;

  modport source (output valid, q_x, q_y, q_z, q_w, degenerate, input ready);
  modport sink (input valid, q_x, q_y, q_z, q_w, degenerate, output ready);
endinterface

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

// Rotation matrix to quaternion converter. Takes one 3x3 matrix per cycle,
// unless the output stalls, in signed fixed point (18-bit Q1.16 by default) and
// returns x, y, z, w in the same format, saturated, with a degenerate flag (and
// all-zero components) when the chosen radicand is not positive. The block is a
// fully pipelined datapath: one input stage, a square-root pipeline of one
// stage per root bit, a divider of one stage per quotient bit plus one entry
// stage, and the output register. A new item can enter before the last one is
// through. The whole pipeline holds while a finished result waits to be taken.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmq_in_if.sink      in_i,
  rmq_out_if.source   out_o
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned M     = (W > F + 1) ? W : F + 1;
  localparam int unsigned TW    = M + 3;
  localparam int unsigned NW    = TW - 1 + F;
  localparam int unsigned NE    = NW + (NW % 2);
  localparam int unsigned RW    = NE / 2;
  localparam int unsigned MAG_W = W + 1;
  localparam int unsigned NUMW  = ((MAG_W + F > RW) ? MAG_W + F : RW) + 1;
  localparam int unsigned SQ_SW = CtrlW + 3 * MAG_W;

  localparam logic signed [TW-1:0] ONE_T  = TW'(1) << F;
  localparam logic [NUMW-1:0]      HI_Q   = NUMW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [NUMW-1:0]      HALF_Q = NUMW'(64'd1 << (W - 1));

  logic en;

  // Saturate an unsigned magnitude with a sign to the output format.
  function automatic logic [W-1:0] sat_mag(input logic [NUMW-1:0] q, input logic neg);
    logic [W-1:0] res;
    if (neg) begin
      res = (q >= HALF_Q) ? {1'b1, {(W-1){1'b0}}} : W'(-q[W-1:0]);
    end else begin
      res = (q > HI_Q) ? HI_Q[W-1:0] : q[W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Input stage: branch choice, radicand and off-diagonal pairs.
  logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [TW-1:0] dif, sum, t, pa, pb, pc;
  main_idx_e            idx;
  logic                 degen;
  logic [TW-1:0]        abs_a, abs_b, abs_c;

  always_comb begin
    e00 = TW'(in_i.m00);
    e01 = TW'(in_i.m01);
    e02 = TW'(in_i.m02);
    e10 = TW'(in_i.m10);
    e11 = TW'(in_i.m11);
    e12 = TW'(in_i.m12);
    e20 = TW'(in_i.m20);
    e21 = TW'(in_i.m21);
    e22 = TW'(in_i.m22);
    dif = e11 - e00;
    sum = e11 + e00;
    if (e22 <= 0) begin
      if (dif <= 0) begin
        idx = MAIN_X;
        t   = ONE_T - e22 - dif;
        pa  = e01 + e10;
        pb  = e02 + e20;
        pc  = e12 - e21;
      end else begin
        idx = MAIN_Y;
        t   = ONE_T - e22 + dif;
        pa  = e01 + e10;
        pb  = e12 + e21;
        pc  = e20 - e02;
      end
    end else begin
      if (sum <= 0) begin
        idx = MAIN_Z;
        t   = ONE_T + e22 - sum;
        pa  = e02 + e20;
        pb  = e12 + e21;
        pc  = e01 - e10;
      end else begin
        idx = MAIN_W;
        t   = ONE_T + e22 + sum;
        pa  = e12 - e21;
        pb  = e20 - e02;
        pc  = e01 - e10;
      end
    end
    degen = (t <= 0);
    abs_a = pa[TW-1] ? -pa : pa;
    abs_b = pb[TW-1] ? -pb : pb;
    abs_c = pc[TW-1] ? -pc : pc;
  end

  logic                  s0_valid_q;
  logic [NE-1:0]         s0_rad_q;
  ctrl_t                 s0_ctrl_q;
  logic [2:0][MAG_W-1:0] s0_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_rad_q        <= degen ? '0 : NE'({t[TW-2:0], {F{1'b0}}});
      s0_ctrl_q.degen <= degen;
      s0_ctrl_q.idx   <= idx;
      s0_ctrl_q.neg_a <= pa[TW-1];
      s0_ctrl_q.neg_b <= pb[TW-1];
      s0_ctrl_q.neg_c <= pc[TW-1];
      s0_mag_q[0]     <= abs_a[MAG_W-1:0];
      s0_mag_q[1]     <= abs_b[MAG_W-1:0];
      s0_mag_q[2]     <= abs_c[MAG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Square root of the scaled radicand.
  logic                  sq_valid;
  logic [RW-1:0]         sq_root;
  logic [SQ_SW-1:0]      sq_side;
  ctrl_t                 sq_ctrl;
  logic [2:0][MAG_W-1:0] sq_mag;

  rmq_sqrt_pipe #(
    .NE     (NE),
    .SIDE_W (SQ_SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .rad_i   (s0_rad_q),
    .side_i  ({s0_ctrl_q, s0_mag_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign {sq_ctrl, sq_mag} = sq_side;

  // ---------------------------------------------------------------------
  // Scale the three pairs by one over twice the root.
  logic                 dv_valid;
  logic [RW-1:0]        dv_root;
  logic [2:0][NUMW-1:0] dv_quo;
  ctrl_t                dv_ctrl;

  rmq_div_pipe #(
    .MAG_W  (MAG_W),
    .FRAC   (F),
    .RW     (RW),
    .NUMW   (NUMW),
    .SIDE_W (CtrlW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .mag_i   (sq_mag),
    .side_i  (sq_ctrl),
    .valid_o (dv_valid),
    .root_o  (dv_root),
    .quo_o   (dv_quo),
    .side_o  (dv_ctrl)
  );

  // ---------------------------------------------------------------------
  // Output register: saturate and place the components.
  logic [RW:0]    big_w;
  logic [W-1:0]   big_s, qa_s, qb_s, qc_s;
  logic [W-1:0]   x_d, y_d, z_d, w_d;
  logic           out_valid_q;
  logic [W-1:0]   x_q, y_q, z_q, w_q;
  logic           degen_q;

  always_comb begin
    big_w = ({1'b0, dv_root} + (RW + 1)'(1)) >> 1;
    big_s = sat_mag(NUMW'(big_w), 1'b0);
    qa_s  = sat_mag(dv_quo[0], dv_ctrl.neg_a);
    qb_s  = sat_mag(dv_quo[1], dv_ctrl.neg_b);
    qc_s  = sat_mag(dv_quo[2], dv_ctrl.neg_c);
    unique case (dv_ctrl.idx)
      MAIN_X: begin
        x_d = big_s; y_d = qa_s; z_d = qb_s; w_d = qc_s;
      end
      MAIN_Y: begin
        x_d = qa_s; y_d = big_s; z_d = qb_s; w_d = qc_s;
      end
      MAIN_Z: begin
        x_d = qa_s; y_d = qb_s; z_d = big_s; w_d = qc_s;
      end
      default: begin
        x_d = qa_s; y_d = qb_s; z_d = qc_s; w_d = big_s;
      end
    endcase
    if (dv_ctrl.degen) begin
      x_d = '0; y_d = '0; z_d = '0; w_d = '0;
    end
  end

  // The pipeline moves unless a finished result waits at the output.
  assign en = !(out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      w_q     <= w_d;
      degen_q <= dv_ctrl.degen;
    end
  end

  assign in_i.ready       = en;
  assign out_o.valid      = out_valid_q;
  assign out_o.q_x        = x_q;
  assign out_o.q_y        = y_q;
  assign out_o.q_z        = z_q;
  assign out_o.q_w        = w_q;
  assign out_o.degenerate = degen_q;

`ifndef SYNTHESIS
  // A degenerate result carries all-zero components.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && degen_q) |-> (x_q == '0 && y_q == '0 && z_q == '0 && w_q == '0))
    else $error("degenerate result with nonzero components");

  // Input is refused only while a result waits at the output.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_valid_q && !out_o.ready))
    else $error("input refused without an output stall");

  // An accepted matrix enters the first pipeline stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s0_valid_q)
    else $error("accepted item lost at pipeline entry");

  // A nondegenerate item always has a nonzero root.
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid && !dv_ctrl.degen) |-> (dv_root != '0))
    else $error("zero root on a positive radicand");
`endif

endmodule

// ===== rtl/core/rmq_sqrt_pipe.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage.
module rmq_sqrt_pipe #(
  parameter int unsigned NE     = 38,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NE-1:0]     rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NE/2-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned RW = NE / 2;

  logic              valid_q [RW];
  logic [NE-1:0]     rad_q   [RW];
  logic [RW+1:0]     rem_q   [RW];
  logic [RW-1:0]     root_q  [RW];
  logic [SIDE_W-1:0] side_q  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic              valid_p;
    logic [NE-1:0]     rad_p;
    logic [RW+1:0]     rem_p;
    logic [RW-1:0]     root_p;
    logic [SIDE_W-1:0] side_p;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign valid_p = valid_i;
      assign rad_p   = rad_i;
      assign rem_p   = '0;
      assign root_p  = '0;
      assign side_p  = side_i;
    end else begin : g_next
      assign valid_p = valid_q[s-1];
      assign rad_p   = rad_q[s-1];
      assign rem_p   = rem_q[s-1];
      assign root_p  = root_q[s-1];
      assign side_p  = side_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_p[RW-1:0], rad_p[NE-1-2*s -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_p;
        rem_q[s]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[s] <= {root_p[RW-2:0], ge};
        side_q[s] <= side_p;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== rtl/core/rmq_div_pipe.sv =====
`timescale 1ns / 1ps

// Three-lane pipelined restoring divider: q = ((mag << F) + r) / (2r),
// one quotient bit per stage after an entry stage that forms the numerators.
module rmq_div_pipe #(
  parameter int unsigned MAG_W  = 19,
  parameter int unsigned FRAC   = 16,
  parameter int unsigned RW     = 19,
  parameter int unsigned NUMW   = 36,
  parameter int unsigned SIDE_W = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [RW-1:0]             root_i,
  input  logic [2:0][MAG_W-1:0]     mag_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [RW-1:0]             root_o,
  output logic [2:0][NUMW-1:0]      quo_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned STG = NUMW + 1;

  logic                 valid_q [STG];
  logic [RW-1:0]        root_q  [STG];
  logic [SIDE_W-1:0]    side_q  [STG];
  logic [2:0][NUMW-1:0] num_q   [STG];
  logic [2:0][RW+1:0]   rem_q   [STG];
  logic [2:0][NUMW-1:0] quo_q   [STG];

  // Entry stage: numerator with the rounding term added.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q[0] <= root_i;
      side_q[0] <= side_i;
      for (int l = 0; l < 3; l++) begin
        num_q[0][l] <= NUMW'({mag_i[l], {FRAC{1'b0}}}) + NUMW'(root_i);
        rem_q[0][l] <= '0;
        quo_q[0][l] <= '0;
      end
    end
  end

  for (genvar k = 1; k < STG; k++) begin : g_stage
    logic [RW:0]          dv;
    logic [2:0][RW+1:0]   rem_sh;
    logic [2:0]           ge;

    assign dv = {root_q[k-1], 1'b0};

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_sh[l] = {rem_q[k-1][l][RW:0], num_q[k-1][l][NUMW-k]};
        ge[l]     = (rem_sh[l] >= {1'b0, dv});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_q[k-1];
        side_q[k] <= side_q[k-1];
        num_q[k]  <= num_q[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= ge[l] ? (rem_sh[l] - {1'b0, dv}) : rem_sh[l];
          quo_q[k][l] <= {quo_q[k-1][l][NUMW-2:0], ge[l]};
        end
      end
    end
  end

  assign valid_o = valid_q[STG-1];
  assign root_o  = root_q[STG-1];
  assign quo_o   = quo_q[STG-1];
  assign side_o  = side_q[STG-1];

endmodule

// ===== tb/rotation_matrix_to_quaternion_tb.sv =====
`timescale 1ns / 1ps

// One converted matrix as the block should present it.
typedef struct {
  logic signed [17:0] q_x, q_y, q_z, q_w;
  logic               degenerate;
} quat_t;

// Keeps the quaternions still owed by the converter and checks each result.
class quat_scoreboard;
  quat_t pending_q[$];
  int    errors;

  function new();
    errors = 0;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Pair value divided by 2r, ties rounded away from zero.
  static function longint pair_scale(longint s, longint unsigned r);
    longint unsigned mag, q;
    mag = (s < 0) ? longint'(-s) : s;
    q = ((mag << 16) + r) / (2 * r);
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  static function logic signed [17:0] clip(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return v[17:0];
  endfunction

  // Notes an accepted matrix and works out the quaternion it should give.
  function void note_matrix(longint m[9]);
    longint t, a, b, c, big, d;
    longint q[4];
    longint unsigned r;
    rmq_pkg::main_idx_e idx;
    quat_t e;
    if (m[8] <= 0) begin
      d = m[4] - m[0];
      if (d <= 0) begin
        idx = rmq_pkg::MAIN_X; t = 65536 - m[8] - d;
        a = m[1] + m[3]; b = m[2] + m[6]; c = m[5] - m[7];
      end else begin
        idx = rmq_pkg::MAIN_Y; t = 65536 - m[8] + d;
        a = m[1] + m[3]; b = m[5] + m[7]; c = m[6] - m[2];
      end
    end else begin
      d = m[4] + m[0];
      if (d <= 0) begin
        idx = rmq_pkg::MAIN_Z; t = 65536 + m[8] - d;
        a = m[2] + m[6]; b = m[5] + m[7]; c = m[1] - m[3];
      end else begin
        idx = rmq_pkg::MAIN_W; t = 65536 + m[8] + d;
        a = m[5] - m[7]; b = m[6] - m[2]; c = m[1] - m[3];
      end
    end
    if (t <= 0) begin
      e = '{0, 0, 0, 0, 1'b1};
    end else begin
      r = int_sqrt(longint'(t) << 16);
      big = (r + 1) >> 1;
      a = pair_scale(a, r);
      b = pair_scale(b, r);
      c = pair_scale(c, r);
      case (idx)
        rmq_pkg::MAIN_X: q = '{big, a, b, c};
        rmq_pkg::MAIN_Y: q = '{a, big, b, c};
        rmq_pkg::MAIN_Z: q = '{a, b, big, c};
        default:         q = '{a, b, c, big};
      endcase
      e = '{clip(q[0]), clip(q[1]), clip(q[2]), clip(q[3]), 1'b0};
    end
    pending_q.push_back(e);
  endfunction

  function void check_quat(quat_t got);
    quat_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result x=%0d y=%0d z=%0d w=%0d", got.q_x, got.q_y, got.q_z,
             got.q_w);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.q_x !== e.q_x) begin
      $error("q_x: expected %0d, got %0d", e.q_x, got.q_x); errors++;
    end
    if (got.q_y !== e.q_y) begin
      $error("q_y: expected %0d, got %0d", e.q_y, got.q_y); errors++;
    end
    if (got.q_z !== e.q_z) begin
      $error("q_z: expected %0d, got %0d", e.q_z, got.q_z); errors++;
    end
    if (got.q_w !== e.q_w) begin
      $error("q_w: expected %0d, got %0d", e.q_w, got.q_w); errors++;
    end
    if (got.degenerate !== e.degenerate) begin
      $error("degenerate: expected %0b, got %0b", e.degenerate, got.degenerate);
      errors++;
    end
  endfunction
endclass

module rotation_matrix_to_quaternion_tb;
  localparam int  Latency    = 57;
  localparam longint MaxCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  rmq_in_if  #(.W(18)) in_ch();
  rmq_out_if #(.W(18)) out_ch();

  quat_scoreboard quat_sb = new();
  int  send_idle_pct = 0;
  int  sink_stall_pct = 0;
  bit  sink_hold = 1'b0;
  longint cycle_cnt = 0;
  int  degen_seen = 0;
  int  results_seen = 0;

  always #1 clk_i = ~clk_i;

  rotation_matrix_to_quaternion u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("rotation_matrix_to_quaternion_tb: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, checks each transfer.
  always @(posedge clk_i) begin
    quat_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.q_x, out_ch.q_y, out_ch.q_z, out_ch.q_w, out_ch.degenerate};
      quat_sb.check_quat(got);
      results_seen++;
      if (got.degenerate) degen_seen++;
    end
    out_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  // Offers one matrix and waits for its transfer. Valid drops only while
  // the sender idles, so back-to-back items keep it high.
  task automatic send_matrix(longint m[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.m00 <= m[0]; in_ch.m01 <= m[1]; in_ch.m02 <= m[2];
    in_ch.m10 <= m[3]; in_ch.m11 <= m[4]; in_ch.m12 <= m[5];
    in_ch.m20 <= m[6]; in_ch.m21 <= m[7]; in_ch.m22 <= m[8];
    do @(posedge clk_i); while (!in_ch.ready);
    quat_sb.note_matrix(m);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (quat_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic longint rand_elem();
    return longint'($urandom_range(262143)) - 131072;
  endfunction

  // Mostly near-rotations: a random unit quaternion turned into a matrix,
  // with a little noise; the rest raw random matrices.
  task automatic send_random();
    longint m[9];
    real x, y, z, w, n;
    int k;
    if ($urandom_range(99) < 75) begin
      x = $urandom_range(2000) - 1000.0; y = $urandom_range(2000) - 1000.0;
      z = $urandom_range(2000) - 1000.0; w = $urandom_range(2000) - 1000.0;
      n = $sqrt(x * x + y * y + z * z + w * w) + 1e-9;
      x /= n; y /= n; z /= n; w /= n;
      m[0] = $rtoi(65536.0 * (1 - 2 * (y * y + z * z)));
      m[1] = $rtoi(65536.0 * 2 * (x * y + z * w));
      m[2] = $rtoi(65536.0 * 2 * (x * z - y * w));
      m[3] = $rtoi(65536.0 * 2 * (x * y - z * w));
      m[4] = $rtoi(65536.0 * (1 - 2 * (x * x + z * z)));
      m[5] = $rtoi(65536.0 * 2 * (y * z + x * w));
      m[6] = $rtoi(65536.0 * 2 * (x * z + y * w));
      m[7] = $rtoi(65536.0 * 2 * (y * z - x * w));
      m[8] = $rtoi(65536.0 * (1 - 2 * (x * x + y * y)));
      for (k = 0; k < 9; k++) begin
        m[k] += longint'($urandom_range(64)) - 32;
        if (m[k] > 131071) m[k] = 131071;
        if (m[k] < -131072) m[k] = -131072;
      end
    end else begin
      for (k = 0; k < 9; k++) m[k] = rand_elem();
    end
    send_matrix(m);
  endtask

  initial begin
    longint mx, mn, one;
    int ph, i, k;
    longint m[9];
    mx = 131071;
    mn = -131072;
    one = 65536;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, the four main-component branches, zero ties
    // and extremes.
    send_matrix('{one, 0, 0, 0, one, 0, 0, 0, one});
    send_matrix('{one, 0, 0, 0, -one, 0, 0, 0, -one});
    send_matrix('{-one, 0, 0, 0, one, 0, 0, 0, -one});
    send_matrix('{-one, 0, 0, 0, -one, 0, 0, 0, one});
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 1});
    send_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn});
    send_matrix('{mx, mn, mx, mn, mn, mx, mn, mx, mx});
    send_matrix('{mn, mx, mn, mx, mx, mn, mx, mn, mn});
    send_matrix('{mx, 0, 0, 0, mx, 0, 0, 0, mn});
    send_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mx});
    send_matrix('{mn, mx, mx, mn, mn, mx, mx, mn, mx});
    send_matrix('{mx, mx, mn, mx, mn, mn, mx, mn, 1});
    send_matrix('{mn, 5, 3, -5, mn, 7, 1, 2, mx});
    send_matrix('{0, 1, 0, -1, 0, 0, 0, 0, -one});
    send_matrix('{-1, 1, -1, 1, -1, 1, -1, 1, -1});
    send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    wait_drained();

    // Random phases under each idling mode.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 70 : 0;
      sink_stall_pct = (ph == 2 || ph == 3) ? 70 : 0;
      if (ph == 3) begin send_idle_pct = 14; sink_stall_pct = 14; end
      for (i = 0; i < 300; i++) send_random();
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0; sink_stall_pct = 0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      for (k = 0; k < 80; k++) send_random();
    join
    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);

    $display("Covered %0d matrices (%0d degenerate), all four main-component branches,",
             results_seen, degen_seen);
    $display("saturating extremes, random stalls on both sides and a full-pipeline hold.");
    if (quat_sb.errors == 0 && quat_sb.pending_q.size() == 0) begin
      $display("rotation_matrix_to_quaternion_tb: done, clean");
    end else begin
      $display("rotation_matrix_to_quaternion_tb: done, errors");
    end
    $finish;
  end
endmodule
